/* hw/rtl/emd_pkg.sv */
package emd_pkg;

  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int ResultW = 34;
  localparam int AccW    = 36;
  localparam int KW      = 11;
  localparam int DbW     = 9;
  localparam int StepW   = 4;

  // raw timestamp pair as taken from the input channel
  typedef struct packed {
    logic [YearW-1:0]   entry_year;
    logic [MonthW-1:0]  entry_month;
    logic [DayW-1:0]    entry_day;
    logic [HourW-1:0]   entry_hour;
    logic [MinuteW-1:0] entry_minute;
    logic [YearW-1:0]   exit_year;
    logic [MonthW-1:0]  exit_month;
    logic [DayW-1:0]    exit_day;
    logic [HourW-1:0]   exit_hour;
    logic [MinuteW-1:0] exit_minute;
  } item_t;

  typedef logic [StepW-1:0] step_t;

  typedef enum logic [3:0] {
    SRC_ZERO, SRC_A, SRC_B,
    SRC_XY, SRC_EY, SRC_DBX, SRC_DBE, SRC_DDX, SRC_DDE,
    SRC_XH, SRC_EH, SRC_XM, SRC_EM
  } src_t;

  typedef enum logic [2:0] {
    OP_LOAD, OP_ADD, OP_SUB, OP_MUL, OP_SAT
  } op_t;

  typedef enum logic [1:0] {
    K_365, K_1440, K_60
  } kmul_t;

  typedef enum logic {
    COND_NONE, COND_NEG
  } cond_t;

  typedef struct packed {
    src_t  src;
    op_t   op;
    kmul_t kmul;
    logic  to_b;
    cond_t cond;
    step_t target;
    logic  done;
    logic  set_err;
  } ctrl_word_t;

  typedef struct packed {
    logic load;
    logic we;
  } dp_ctl_t;

  typedef struct packed {
    logic                      neg;
    logic signed [ResultW-1:0] result;
  } dp_stat_t;

  localparam step_t StepErr = step_t'(15);

  function automatic ctrl_word_t cw_make(src_t s, op_t o, kmul_t k, logic to_b,
                                         cond_t c, step_t t, logic dn, logic er);
    ctrl_word_t w;
    w.src     = s;
    w.op      = o;
    w.kmul    = k;
    w.to_b    = to_b;
    w.cond    = c;
    w.target  = t;
    w.done    = dn;
    w.set_err = er;
    return w;
  endfunction

  function automatic logic [KW-1:0] kval(kmul_t k);
    case (k)
      K_365:   return KW'(365);
      K_1440:  return KW'(1440);
      K_60:    return KW'(60);
      default: return '0;
    endcase
  endfunction

  // month index 0..11, no leap years
  function automatic logic [DayW-1:0] month_len(logic [MonthW-1:0] mi);
    case (mi)
      4'd1:                      return DayW'(28);
      4'd3, 4'd5, 4'd8, 4'd10:   return DayW'(30);
      default:                   return DayW'(31);
    endcase
  endfunction

  function automatic logic [DbW-1:0] days_before(logic [MonthW-1:0] mi);
    case (mi)
      4'd0:    return DbW'(0);
      4'd1:    return DbW'(31);
      4'd2:    return DbW'(59);
      4'd3:    return DbW'(90);
      4'd4:    return DbW'(120);
      4'd5:    return DbW'(151);
      4'd6:    return DbW'(181);
      4'd7:    return DbW'(212);
      4'd8:    return DbW'(243);
      4'd9:    return DbW'(273);
      4'd10:   return DbW'(304);
      4'd11:   return DbW'(334);
      default: return DbW'(0);
    endcase
  endfunction

  function automatic logic [MonthW-1:0] month_index(logic [MonthW-1:0] m);
    if (m == '0) return '0;
    if (m > MonthW'(12)) return MonthW'(11);
    return m - MonthW'(1);
  endfunction

  // zero-based day of month after clamping to the month
  function automatic logic [DayW-1:0] day_offset(logic [MonthW-1:0] mi, logic [DayW-1:0] d);
    logic [DayW-1:0] len;
    len = month_len(mi);
    if (d == '0) return '0;
    if (d > len) return len - DayW'(1);
    return d - DayW'(1);
  endfunction

endpackage

/* hw/rtl/emd_if.sv */
interface emd_in_if import emd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YearW-1:0]   entry_year;
  logic [MonthW-1:0]  entry_month;
  logic [DayW-1:0]    entry_day;
  logic [HourW-1:0]   entry_hour;
  logic [MinuteW-1:0] entry_minute;
  logic [YearW-1:0]   exit_year;
  logic [MonthW-1:0]  exit_month;
  logic [DayW-1:0]    exit_day;
  logic [HourW-1:0]   exit_hour;
  logic [MinuteW-1:0] exit_minute;

  modport source (
    output valid, entry_year, entry_month, entry_day, entry_hour, entry_minute,
    output exit_year, exit_month, exit_day, exit_hour, exit_minute,
    input  ready
  );
  modport sink (
    input  valid, entry_year, entry_month, entry_day, entry_hour, entry_minute,
    input  exit_year, exit_month, exit_day, exit_hour, exit_minute,
    output ready
  );
endinterface

interface emd_out_if import emd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ResultW-1:0] elapsed_minutes;
  logic                      order_error;

  modport source (output valid, elapsed_minutes, order_error, input ready);
  modport sink (input valid, elapsed_minutes, order_error, output ready);
endinterface

/* hw/rtl/emd_ucode_rom.sv */
module emd_ucode_rom import emd_pkg::*; (
  input  step_t      step,
  output ctrl_word_t cw
);

  // a = day number of exit minus day number of entry, then scaled and
  // adjusted by the time of day difference
  always_comb begin
    case (step)
      4'd0:    cw = cw_make(SRC_XY,   OP_MUL,  K_365,  1'b0, COND_NONE, '0, 1'b0, 1'b0);
      4'd1:    cw = cw_make(SRC_DBX,  OP_ADD,  K_365,  1'b0, COND_NONE, '0, 1'b0, 1'b0);
      4'd2:    cw = cw_make(SRC_DDX,  OP_ADD,  K_365,  1'b0, COND_NONE, '0, 1'b0, 1'b0);
      4'd3:    cw = cw_make(SRC_EY,   OP_MUL,  K_365,  1'b1, COND_NONE, '0, 1'b0, 1'b0);
      4'd4:    cw = cw_make(SRC_B,    OP_SUB,  K_365,  1'b0, COND_NONE, '0, 1'b0, 1'b0);
      4'd5:    cw = cw_make(SRC_DBE,  OP_SUB,  K_365,  1'b0, COND_NONE, '0, 1'b0, 1'b0);
      // exit date before entry date
      4'd6:    cw = cw_make(SRC_DDE,  OP_SUB,  K_365,  1'b0, COND_NEG, StepErr, 1'b0, 1'b0);
      4'd7:    cw = cw_make(SRC_A,    OP_MUL,  K_1440, 1'b0, COND_NONE, '0, 1'b0, 1'b0);
      4'd8:    cw = cw_make(SRC_XH,   OP_MUL,  K_60,   1'b1, COND_NONE, '0, 1'b0, 1'b0);
      4'd9:    cw = cw_make(SRC_B,    OP_ADD,  K_60,   1'b0, COND_NONE, '0, 1'b0, 1'b0);
      4'd10:   cw = cw_make(SRC_EH,   OP_MUL,  K_60,   1'b1, COND_NONE, '0, 1'b0, 1'b0);
      4'd11:   cw = cw_make(SRC_B,    OP_SUB,  K_60,   1'b0, COND_NONE, '0, 1'b0, 1'b0);
      4'd12:   cw = cw_make(SRC_XM,   OP_ADD,  K_60,   1'b0, COND_NONE, '0, 1'b0, 1'b0);
      4'd13:   cw = cw_make(SRC_EM,   OP_SUB,  K_60,   1'b0, COND_NONE, '0, 1'b0, 1'b0);
      4'd14:   cw = cw_make(SRC_A,    OP_SAT,  K_60,   1'b0, COND_NONE, '0, 1'b1, 1'b0);
      4'd15:   cw = cw_make(SRC_ZERO, OP_LOAD, K_60,   1'b0, COND_NONE, '0, 1'b1, 1'b1);
      default: cw = cw_make(SRC_ZERO, OP_LOAD, K_60,   1'b0, COND_NONE, '0, 1'b1, 1'b1);
    endcase
  end

endmodule

/* hw/rtl/emd_datapath.sv */
module emd_datapath import emd_pkg::*; (
  input  logic       clk,
  input  item_t      item,
  input  dp_ctl_t    ctl,
  input  ctrl_word_t cw,
  output dp_stat_t   stat
);

  localparam logic signed [AccW-1:0] SatMax = AccW'(64'd8589934591);

  logic [YearW-1:0]   xy, ey;
  logic [DbW-1:0]     dbx, dbe;
  logic [DayW-1:0]    ddx, dde;
  logic [HourW-1:0]   xh, eh;
  logic [MinuteW-1:0] xm, em;

  logic signed [AccW-1:0]    a, b;
  logic signed [AccW-1:0]    opnd, alu;
  logic signed [AccW+KW:0]   prod;
  logic [MonthW-1:0]         mi_x, mi_e;

  assign mi_x = month_index(item.exit_month);
  assign mi_e = month_index(item.entry_month);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      xy  <= item.exit_year;
      ey  <= item.entry_year;
      dbx <= days_before(mi_x);
      dbe <= days_before(mi_e);
      ddx <= day_offset(mi_x, item.exit_day);
      dde <= day_offset(mi_e, item.entry_day);
      xh  <= item.exit_hour;
      eh  <= item.entry_hour;
      xm  <= item.exit_minute;
      em  <= item.entry_minute;
    end
  end

  always_comb begin
    case (cw.src)
      SRC_A:   opnd = a;
      SRC_B:   opnd = b;
      SRC_XY:  opnd = AccW'(xy);
      SRC_EY:  opnd = AccW'(ey);
      SRC_DBX: opnd = AccW'(dbx);
      SRC_DBE: opnd = AccW'(dbe);
      SRC_DDX: opnd = AccW'(ddx);
      SRC_DDE: opnd = AccW'(dde);
      SRC_XH:  opnd = AccW'(xh);
      SRC_EH:  opnd = AccW'(eh);
      SRC_XM:  opnd = AccW'(xm);
      SRC_EM:  opnd = AccW'(em);
      default: opnd = '0;
    endcase
  end

  assign prod = opnd * $signed({1'b0, kval(cw.kmul)});

  always_comb begin
    case (cw.op)
      OP_LOAD: alu = opnd;
      OP_ADD:  alu = a + opnd;
      OP_SUB:  alu = a - opnd;
      OP_MUL:  alu = prod[AccW-1:0];
      OP_SAT:  alu = (opnd > SatMax) ? SatMax : opnd;
      default: alu = opnd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      if (cw.to_b) begin
        b <= alu;
      end else begin
        a <= alu;
      end
    end
  end

  assign stat.neg    = alu[AccW-1];
  assign stat.result = alu[ResultW-1:0];

endmodule

/* hw/rtl/emd_seq.sv */
module emd_seq import emd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output logic signed [ResultW-1:0] rsp_minutes,
  output logic                      rsp_error,
  input  ctrl_word_t                cw,
  input  dp_stat_t                  stat,
  output step_t                     step,
  output dp_ctl_t                   ctl
);

  logic busy;
  logic out_free;
  logic finish;

  assign req_ready = !busy;
  assign out_free  = !rsp_valid || rsp_ready;
  // the last step waits while the result register is still held
  assign finish    = busy && cw.done && out_free;

  assign ctl.load = req_valid && req_ready;
  assign ctl.we   = busy && (!cw.done || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (ctl.load) begin
      busy <= 1'b1;
      step <= '0;
    end else if (finish) begin
      busy <= 1'b0;
    end else if (busy && !cw.done) begin
      if (cw.cond == COND_NEG && stat.neg) begin
        step <= cw.target;
      end else begin
        step <= step + step_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp_minutes <= stat.result;
      rsp_error   <= cw.set_err;
    end
  end

endmodule

/* hw/rtl/elapsed_minutes_between_dates.sv */
// channel | dir | handshake     | payload
// req     | in  | valid / ready | entry and exit year, month, day, hour, minute
// rsp     | out | valid / ready | elapsed_minutes, order_error
//
// one transaction at a time through a 16-step microprogram over one shared alu
// a normal transaction runs the microprogram through to its saturating step,
// one whose exit date lies before the entry date branches to the error step
// the result register lets a new transaction in while the last result waits
// the final step stalls while the result register is full
// rst is synchronous and clears the sequencer and result valid
module elapsed_minutes_between_dates import emd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  emd_in_if.sink    req,
  emd_out_if.source rsp
);

  item_t      item;
  step_t      step;
  ctrl_word_t cw;
  dp_ctl_t    ctl;
  dp_stat_t   stat;

  assign item.entry_year   = req.entry_year;
  assign item.entry_month  = req.entry_month;
  assign item.entry_day    = req.entry_day;
  assign item.entry_hour   = req.entry_hour;
  assign item.entry_minute = req.entry_minute;
  assign item.exit_year    = req.exit_year;
  assign item.exit_month   = req.exit_month;
  assign item.exit_day     = req.exit_day;
  assign item.exit_hour    = req.exit_hour;
  assign item.exit_minute  = req.exit_minute;

  emd_ucode_rom u_rom (
    .step (step),
    .cw   (cw)
  );

  emd_datapath u_dp (
    .clk  (clk),
    .item (item),
    .ctl  (ctl),
    .cw   (cw),
    .stat (stat)
  );

  emd_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_minutes (rsp.elapsed_minutes),
    .rsp_error   (rsp.order_error),
    .cw          (cw),
    .stat        (stat),
    .step        (step),
    .ctl         (ctl)
  );

endmodule

/* tb/sv/elapsed_minutes_checker.sv */
`timescale 1ns / 1ps
module elapsed_minutes_checker import emd_pkg::*; (
  input  logic clk,
  input  logic rst,
  emd_in_if    req,
  emd_out_if   rsp,
  output int   mismatches,
  output int   pending
);

  localparam longint SatMax = (longint'(1) << (ResultW - 1)) - 1;

  typedef struct {
    logic signed [ResultW-1:0] minutes;
    logic                      order_err;
  } span_t;

  span_t span_q[$];

  function automatic int days_in_month(int mon);
    case (mon)
      2:            return 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  // days since jan 1 of year 0, month and day pulled into range first
  function automatic longint date_to_days(int yr, int mon, int dom);
    int m;
    int d;
    int acc;
    m = (mon < 1) ? 1 : (mon > 12) ? 12 : mon;
    d = (dom < 1) ? 1 : dom;
    if (d > days_in_month(m)) d = days_in_month(m);
    acc = 0;
    for (int i = 1; i < m; i++) acc += days_in_month(i);
    return longint'(yr) * 365 + acc + d - 1;
  endfunction

  function automatic span_t predict_span(item_t it);
    span_t  s;
    longint from_day;
    longint to_day;
    longint total;
    int     eh, em, xh, xm;
    from_day = date_to_days(it.entry_year, it.entry_month, it.entry_day);
    to_day   = date_to_days(it.exit_year, it.exit_month, it.exit_day);
    eh = it.entry_hour;
    em = it.entry_minute;
    xh = it.exit_hour;
    xm = it.exit_minute;
    if (to_day < from_day) begin
      s.minutes   = '0;
      s.order_err = 1'b1;
    end else begin
      // time of day is ignored by the order check, so this can go negative
      total = (to_day - from_day) * 1440 + longint'(xh - eh) * 60 + (xm - em);
      if (total > SatMax) total = SatMax;
      s.minutes   = total[ResultW-1:0];
      s.order_err = 1'b0;
    end
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch on %s: got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    item_t seen;
    span_t want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        seen = {req.entry_year, req.entry_month, req.entry_day, req.entry_hour,
                req.entry_minute, req.exit_year, req.exit_month, req.exit_day,
                req.exit_hour, req.exit_minute};
        span_q.push_back(predict_span(seen));
      end
      if (rsp.valid && rsp.ready) begin
        if (span_q.size() == 0) begin
          report_mismatch("result with no transaction waiting", rsp.elapsed_minutes, 0);
        end else begin
          want = span_q.pop_front();
          if (rsp.elapsed_minutes !== want.minutes)
            report_mismatch("elapsed_minutes", rsp.elapsed_minutes, want.minutes);
          if (rsp.order_error !== want.order_err)
            report_mismatch("order_error", rsp.order_error, want.order_err);
        end
      end
      pending = span_q.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import emd_pkg::*;

  localparam int ItemCount   = 400;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 32;

  logic   clk;
  logic   rst;
  bit     calm;
  int     mismatches;
  int     pending;
  int     ready_left;
  longint cycle_count;

  emd_in_if  req();
  emd_out_if rsp();

  elapsed_minutes_between_dates dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  elapsed_minutes_checker minutes_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t make_stamp(int ey, int em, int ed, int eh, int emi,
                                       int xy, int xm, int xd, int xh, int xmi);
    item_t s;
    s.entry_year   = YearW'(ey);
    s.entry_month  = MonthW'(em);
    s.entry_day    = DayW'(ed);
    s.entry_hour   = HourW'(eh);
    s.entry_minute = MinuteW'(emi);
    s.exit_year    = YearW'(xy);
    s.exit_month   = MonthW'(xm);
    s.exit_day     = DayW'(xd);
    s.exit_hour    = HourW'(xh);
    s.exit_minute  = MinuteW'(xmi);
    return s;
  endfunction

  function automatic int pick_day();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 28);
  endfunction

  // mostly exit on or after entry, some reversed pairs and some raw noise
  function automatic item_t random_stamp();
    item_t        s;
    logic [95:0]  raw;
    int           kind;
    int           ey;
    kind = $urandom_range(0, 9);
    ey = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 9999);
    s = make_stamp(ey, $urandom_range(1, 12), pick_day(), $urandom_range(0, 23),
                   $urandom_range(0, 59), 0, $urandom_range(1, 12), pick_day(),
                   $urandom_range(0, 23), $urandom_range(0, 59));
    case (kind)
      0: begin
        raw = {$urandom, $urandom, $urandom};
        s = raw[$bits(item_t)-1:0];
      end
      1: begin
        s.exit_year  = s.entry_year;
        s.exit_month = s.entry_month;
        s.exit_day   = s.entry_day;
      end
      5, 6: begin
        s.exit_year = YearW'((ey + 30 > 16383) ? 16383 : ey + $urandom_range(1, 30));
      end
      7: s.exit_year = YearW'($urandom_range(ey, 16383));
      8: s.exit_year = YearW'($urandom_range(0, ey));
      default: begin
        s.exit_year  = s.entry_year;
        s.exit_month = MonthW'($urandom_range(s.entry_month, 12));
        if (s.exit_month == s.entry_month)
          s.exit_day = DayW'($urandom_range(s.entry_day, 31));
      end
    endcase
    return s;
  endfunction

  task automatic send_stamp(item_t s);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req.valid        <= 1'b1;
    req.entry_year   <= s.entry_year;
    req.entry_month  <= s.entry_month;
    req.entry_day    <= s.entry_day;
    req.entry_hour   <= s.entry_hour;
    req.entry_minute <= s.entry_minute;
    req.exit_year    <= s.exit_year;
    req.exit_month   <= s.exit_month;
    req.exit_day     <= s.exit_day;
    req.exit_hour    <= s.exit_hour;
    req.exit_minute  <= s.exit_minute;
    do @(posedge clk); while (!req.ready);
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (calm) begin
      rsp.ready  <= 1'b1;
      ready_left = 0;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if (rsp.ready) begin
      rsp.ready  <= 1'b0;
      ready_left = pick_gap();
    end else begin
      rsp.ready  <= 1'b1;
      ready_left = $urandom_range(0, 15);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("elapsed_minutes_between_dates verification failed");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    calm         = 1'b0;
    ready_left   = 0;
    cycle_count  = 0;
    rsp.ready    = 1'b0;
    req.valid    = 1'b0;
    req.entry_year   = '0;
    req.entry_month  = '0;
    req.entry_day    = '0;
    req.entry_hour   = '0;
    req.entry_minute = '0;
    req.exit_year    = '0;
    req.exit_month   = '0;
    req.exit_day     = '0;
    req.exit_hour    = '0;
    req.exit_minute  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_stamp(make_stamp(0, 1, 1, 0, 0, 0, 1, 1, 0, 0));
    // same day, exit earlier
    send_stamp(make_stamp(2024, 6, 15, 23, 59, 2024, 6, 15, 0, 0));
    send_stamp(make_stamp(0, 1, 1, 0, 0, 9999, 12, 31, 23, 59));
    // span past the top of the result range
    send_stamp(make_stamp(0, 1, 1, 0, 0, 16383, 12, 31, 23, 59));
    send_stamp(make_stamp(16383, 15, 31, 31, 63, 16383, 15, 31, 31, 63));
    send_stamp(make_stamp(16383, 15, 31, 31, 63, 0, 0, 0, 0, 0));
    // exit a day early with a later time of day
    send_stamp(make_stamp(100, 3, 2, 8, 0, 100, 3, 1, 20, 0));
    send_stamp(make_stamp(101, 1, 1, 0, 0, 100, 12, 31, 23, 59));
    // month and day zero
    send_stamp(make_stamp(50, 0, 0, 0, 0, 50, 1, 1, 0, 0));
    send_stamp(make_stamp(50, 13, 5, 0, 0, 50, 12, 5, 0, 0));
    // days past the month end
    send_stamp(make_stamp(50, 2, 31, 12, 0, 50, 3, 1, 12, 0));
    send_stamp(make_stamp(50, 2, 30, 10, 0, 50, 2, 28, 9, 0));
    send_stamp(make_stamp(50, 4, 31, 0, 0, 50, 5, 1, 0, 0));
    send_stamp(make_stamp(300, 11, 30, 0, 0, 300, 11, 31, 0, 0));
    // hour and minute beyond a day
    send_stamp(make_stamp(7, 5, 5, 31, 63, 7, 5, 5, 0, 0));
    send_stamp(make_stamp(7, 5, 5, 0, 0, 7, 5, 5, 31, 63));
    send_stamp(make_stamp(7, 12, 31, 23, 59, 8, 1, 1, 0, 0));
    send_stamp(make_stamp(9998, 1, 1, 0, 0, 9999, 1, 1, 0, 0));
    send_stamp(make_stamp(8191, 7, 15, 12, 30, 8192, 7, 15, 12, 30));
    send_stamp(make_stamp(0, 1, 1, 23, 59, 0, 1, 2, 0, 0));

    for (int i = 0; i < ItemCount; i++) begin
      // every fourth stretch runs with no idling on either side
      calm = ((i / 50) % 4) == 3;
      send_stamp(random_stamp());
    end
    @(negedge clk);
    req.valid <= 1'b0;
    calm = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("elapsed_minutes_between_dates verification clean");
    end else begin
      $display("elapsed_minutes_between_dates verification failed");
    end
    $finish;
  end

endmodule
